// ===== rtl/aeg_pkg.sv =====
package aeg_pkg;

  // Default top of the attack ramp.
  localparam int unsigned LEVEL_MAX_DEF = 16383;

  localparam int LEVEL_OUT_W   = 14;
  localparam int PHASE_W       = 3;
  localparam int MODE_W        = 2;
  localparam int STEP_W        = 22;
  localparam int DIVISOR_W     = 16;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 22;

  localparam logic [LEVEL_OUT_W-1:0] LEVEL_OUT_MAX = 14'h3FFF;
  localparam logic [STEP_W-1:0]      STEP_MAX      = 22'h3FFFFF;

  // Item kinds.
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_KEY_ON  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KEY_OFF = 2'd2;

  // Envelope phases.
  localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd3;
  localparam logic [PHASE_W-1:0] PH_OFF     = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_STEP     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_STEP      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SUSTAIN_STEP    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SUSTAIN_LEVEL   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_ENABLE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_DIVISOR = 3'd5;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic div_step;
    logic div_commit;
    logic out_load;
  } aeg_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } aeg_status_t;

endpackage

// ===== rtl/aeg_ctrl.sv =====
module aeg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  aeg_pkg::aeg_status_t status,
  output aeg_pkg::aeg_cmd_t    cmd
);
  import aeg_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CALC;
        end
      end
      S_CALC: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.update = 1'b1;
          state_next = S_OUT;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.div_commit = 1'b1;
          state_next     = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_OUT: begin
        // The result register is free, or its content is leaving in this transfer.
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/aeg_datapath.sv =====
module aeg_datapath #(
  parameter int unsigned LEVEL_MAX = aeg_pkg::LEVEL_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [aeg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [aeg_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [aeg_pkg::MODE_W-1:0]          mode,
  input  logic                                playing,
  input  aeg_pkg::aeg_cmd_t                   cmd,
  output aeg_pkg::aeg_status_t                status,
  output logic [aeg_pkg::LEVEL_OUT_W-1:0]     level,
  output logic [aeg_pkg::PHASE_W-1:0]         phase
);
  import aeg_pkg::*;

  localparam int LVL_BITS = $clog2(LEVEL_MAX + 1);
  // Decay can land on sustain_level, which may lie above a small LEVEL_MAX.
  localparam int LW = (LVL_BITS > LEVEL_OUT_W) ? LVL_BITS : LEVEL_OUT_W;
  localparam int SW = LW + 1;
  localparam int VW = LW + 9;
  localparam int QW = LW + 8;
  localparam int CW = $clog2(LW + 1);

  // Configuration registers.
  logic [STEP_W-1:0]      attack_step;
  logic [STEP_W-1:0]      decay_step;
  logic [LEVEL_OUT_W-1:0] sustain_step;
  logic [LEVEL_OUT_W-1:0] sustain_level;
  logic                   release_enable;
  logic [DIVISOR_W-1:0]   release_divisor;

  // Envelope state.
  logic [LW-1:0]          env_level;
  logic [PHASE_W-1:0]     env_phase;
  logic                   key_off_pending;
  logic [STEP_W-1:0]      release_step;

  // Captured item.
  logic [MODE_W-1:0]      item_mode;
  logic                   item_playing;

  // Divider.
  logic [DIVISOR_W-1:0]   rem;
  logic [LW-1:0]          quo;
  logic [CW-1:0]          div_cnt;
  logic [DIVISOR_W:0]     rem_shift;
  logic [DIVISOR_W:0]     rem_diff;
  logic [QW-1:0]          quo_scaled;
  logic [STEP_W-1:0]      step_sat;

  // Tick update.
  logic [LW-1:0]          tick_level;
  logic [PHASE_W-1:0]     tick_phase;
  logic [SW-1:0]          att_sum;
  logic [SW-1:0]          sus_diff;
  logic [VW-1:0]          dec_v;
  logic [VW-1:0]          rel_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_step     <= STEP_W'(1);
      decay_step      <= '0;
      sustain_step    <= '0;
      sustain_level   <= '0;
      release_enable  <= 1'b0;
      release_divisor <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATTACK_STEP:     attack_step     <= cfg_data[STEP_W-1:0];
        REG_DECAY_STEP:      decay_step      <= cfg_data[STEP_W-1:0];
        REG_SUSTAIN_STEP:    sustain_step    <= cfg_data[LEVEL_OUT_W-1:0];
        REG_SUSTAIN_LEVEL:   sustain_level   <= cfg_data[LEVEL_OUT_W-1:0];
        REG_RELEASE_ENABLE:  release_enable  <= cfg_data[0];
        REG_RELEASE_DIVISOR: release_divisor <= cfg_data[DIVISOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    att_sum    = {1'b0, env_level} + SW'(attack_step[STEP_W-1:8]);
    dec_v      = {1'b0, env_level, 8'h00} - VW'(decay_step);
    sus_diff   = {1'b0, env_level} - SW'(sustain_step);
    rel_v      = {1'b0, env_level, 8'h00} - VW'(release_step);
    tick_level = '0;
    tick_phase = PH_OFF;
    if (item_playing) begin
      case (env_phase)
        PH_ATTACK: begin
          if (att_sum >= SW'(LEVEL_MAX)) begin
            tick_level = LW'(LEVEL_MAX);
            tick_phase = PH_DECAY;
          end else begin
            tick_level = att_sum[LW-1:0];
            tick_phase = PH_ATTACK;
          end
        end
        PH_DECAY: begin
          if (dec_v[VW-1] || (dec_v[VW-2:8] <= LW'(sustain_level))) begin
            tick_level = LW'(sustain_level);
            tick_phase = PH_SUSTAIN;
          end else begin
            tick_level = dec_v[VW-2:8];
            tick_phase = PH_DECAY;
          end
        end
        PH_SUSTAIN: begin
          if (sus_diff[SW-1] || (sus_diff[LW-1:0] == '0)) begin
            tick_level = '0;
            tick_phase = PH_OFF;
          end else begin
            tick_level = sus_diff[LW-1:0];
            if (!key_off_pending) begin
              tick_phase = PH_SUSTAIN;
            end else if (release_enable) begin
              tick_phase = PH_RELEASE;
            end else begin
              tick_phase = PH_OFF;
            end
          end
        end
        PH_RELEASE: begin
          // Anything under one whole level unit after the step ends the note.
          if (rel_v[VW-1] || (rel_v[VW-2:8] == '0)) begin
            tick_level = '0;
            tick_phase = PH_OFF;
          end else begin
            tick_level = rel_v[VW-2:8];
            tick_phase = PH_RELEASE;
          end
        end
        default: begin
          tick_level = '0;
          tick_phase = PH_OFF;
        end
      endcase
    end
  end

  assign status.need_div = (item_mode == MODE_TICK) && item_playing &&
                           (env_phase == PH_SUSTAIN) && key_off_pending &&
                           release_enable && (release_divisor != '0);
  assign status.div_done = (div_cnt == '0);

  assign rem_shift  = {rem, quo[LW-1]};
  assign rem_diff   = rem_shift - {1'b0, release_divisor};
  assign quo_scaled = {quo, 8'h00};
  assign step_sat   = (quo_scaled > QW'(STEP_MAX)) ? STEP_MAX : quo_scaled[STEP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= CW'(LW);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - CW'(1);
    end
  end

  // Restoring division, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      quo <= env_level;
    end else if (cmd.div_step) begin
      if (!rem_diff[DIVISOR_W]) begin
        rem <= rem_diff[DIVISOR_W-1:0];
        quo <= {quo[LW-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DIVISOR_W-1:0];
        quo <= {quo[LW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode    <= mode;
      item_playing <= playing;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env_level       <= '0;
      env_phase       <= PH_OFF;
      key_off_pending <= 1'b0;
      release_step    <= '0;
    end else if (cmd.div_commit) begin
      env_level    <= tick_level;
      env_phase    <= tick_phase;
      release_step <= step_sat;
    end else if (cmd.update) begin
      case (item_mode)
        MODE_TICK: begin
          env_level <= tick_level;
          env_phase <= tick_phase;
        end
        MODE_KEY_ON: begin
          env_level       <= '0;
          env_phase       <= PH_ATTACK;
          key_off_pending <= 1'b0;
        end
        MODE_KEY_OFF: begin
          key_off_pending <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      level <= (env_level > LW'(LEVEL_OUT_MAX)) ? LEVEL_OUT_MAX
                                                : env_level[LEVEL_OUT_W-1:0];
      phase <= env_phase;
    end
  end

endmodule

// ===== rtl/adsr_envelope_generator_top.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  mode, playing
// out      output     out_valid / out_stall level, phase
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// An item goes from transfer to the result register through capture, update and load.
// A tick that starts a release with a non-zero divisor also runs the bit-serial divider,
// which works through W quotient bits, W being the level width (14 at the default LEVEL_MAX).
// A new item is taken while the previous result still waits in the output register.
// Reset is synchronous and returns the voice to off with level zero.
// A stalled output holds the result; the next item then waits before its load.
module adsr_envelope_generator_top #(
  parameter int unsigned LEVEL_MAX = aeg_pkg::LEVEL_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [aeg_pkg::MODE_W-1:0]      mode,
  input  logic                            playing,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [aeg_pkg::LEVEL_OUT_W-1:0] level,
  output logic [aeg_pkg::PHASE_W-1:0]     phase,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [aeg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [aeg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import aeg_pkg::*;

  aeg_cmd_t    cmd;
  aeg_status_t status;

  assign cfg_ready = 1'b1;

  aeg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  aeg_datapath #(
    .LEVEL_MAX (LEVEL_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .playing   (playing),
    .cmd       (cmd),
    .status    (status),
    .level     (level),
    .phase     (phase)
  );

endmodule

// ===== rtl/aeg_checker.sv =====
module aeg_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [aeg_pkg::MODE_W-1:0]      mode,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [aeg_pkg::LEVEL_OUT_W-1:0] level,
  input logic [aeg_pkg::PHASE_W-1:0]     phase
);
  import aeg_pkg::*;

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pending;
  logic       last_key_on;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // Items taken in but whose result has not yet left.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= '0;
      last_key_on <= 1'b0;
    end else begin
      pending <= pending + {1'b0, in_xfer} - {1'b0, out_xfer};
      if (in_xfer) begin
        last_key_on <= (mode == MODE_KEY_ON);
      end
    end
  end

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> (pending != 2'd0))
    else $error("result transfer without an outstanding item");

  a_bounded_backlog: assert property (@(posedge clk) disable iff (rst)
    pending <= 2'd2)
    else $error("more than two items outstanding");

  a_key_on_result: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && (pending == 2'd1) && last_key_on) |-> (phase == PH_ATTACK && level == '0))
    else $error("key-on result is not attack at level zero");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(level) && $stable(phase)))
    else $error("stalled result changed");

endmodule

bind adsr_envelope_generator_top aeg_checker u_aeg_checker (.*);
